FILE: sv/wmpm_pkg.sv
`default_nettype none
package wmpm_pkg;
	localparam int MAX_NODES = 1024;
	localparam int ALPHABET  = 26;
	localparam int NODE_W    = 10;
	localparam int COUNT_W   = 11;
	localparam int SYM_W     = 5;
	localparam int GOTO_AW   = 15;
	localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
	localparam logic [SYM_W-1:0]   LAST_SYM  = SYM_W'(ALPHABET - 1);
	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_NODES);
	localparam logic [31:0] W32MAX = 32'hFFFF_FFFF;
	localparam logic [47:0] W48MAX = 48'hFFFF_FFFF_FFFF;

	// Request kinds.
	localparam logic [2:0] K_CLEAR   = 3'd0;
	localparam logic [2:0] K_INSERT  = 3'd1;
	localparam logic [2:0] K_BUILD   = 3'd2;
	localparam logic [2:0] K_SCAN    = 3'd3;
	localparam logic [2:0] K_RESTART = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_NOLINK = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  symbol;
		logic        pattern_end;
		logic [15:0] weight;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  node;
		logic [31:0] match_weight;
		logic [47:0] total_score;
	} rsp_t;

	// Goto table address: node * 26 + symbol, built from shifts.
	function automatic logic [GOTO_AW-1:0] row_idx(input logic [NODE_W-1:0] n,
			input logic [SYM_W-1:0] s);
		logic [GOTO_AW-1:0] a;
		a = (GOTO_AW'(n) << 4) + (GOTO_AW'(n) << 3) + (GOTO_AW'(n) << 1) + GOTO_AW'(s);
		return a;
	endfunction
endpackage
`default_nettype wire

FILE: sv/wmpm_ram.sv
`default_nettype none
module wmpm_ram #(
	parameter int AW = 10,
	parameter int DW = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/weighted_multi_pattern_matcher_top.sv
// Channel   Ports            Handshake
// request   start, req       taken at a clock edge with start high and busy low
// result    done, rsp        done marks rsp for one cycle, no back pressure
//
// Scan does a goto read, then a weight read, both from registered-read memories.
// Insert reads the goto entry; when a node is created, the new node's 26 goto
// entries are zeroed one per cycle before the parent's edge is written.
// Clear sweeps the root row; restart and no-op kinds answer without leaving idle.
// Build walks the trie breadth first through the single goto read port.
// Reset is asynchronous; busy then stays high while the root row
// and root weight are swept, with no result. The receiver cannot stall.
`default_nettype none
module weighted_multi_pattern_matcher_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire wmpm_pkg::req_t  req,
	output logic                 done,
	output wmpm_pkg::rsp_t       rsp
);
	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_CLR    = 19'h00002,
		S_INS_RD = 19'h00004,
		S_INS_CK = 19'h00008,
		S_INS_Z  = 19'h00010,
		S_INS_LK = 19'h00020,
		S_SC_RD  = 19'h00040,
		S_SC_G   = 19'h00080,
		S_SC_W   = 19'h00100,
		S_B_R0   = 19'h00200,
		S_B_R0D  = 19'h00400,
		S_B_POP  = 19'h00800,
		S_B_POPD = 19'h01000,
		S_B_F    = 19'h02000,
		S_B_WF   = 19'h04000,
		S_B_WN   = 19'h08000,
		S_B_C0   = 19'h10000,
		S_B_C1   = 19'h20000,
		S_B_C2   = 19'h40000
	} state_t;

	state_t state_q;
	wmpm_pkg::req_t req_q;
	logic [wmpm_pkg::COUNT_W-1:0] count_q, head_q, tail_q;
	logic [wmpm_pkg::NODE_W-1:0] cursor_q, scan_q, now_q, f_q, via_q;
	logic [47:0] total_q;
	logic built_q;
	logic boot_q;
	logic [wmpm_pkg::SYM_W-1:0] k_q;
	logic [31:0] wf_q;
	logic done_q;
	wmpm_pkg::rsp_t rsp_q;

	logic g_we, f_we, w_we, q_we;
	logic [wmpm_pkg::GOTO_AW-1:0] g_waddr, g_raddr;
	logic [wmpm_pkg::NODE_W-1:0] g_wdata, g_rdata;
	logic [wmpm_pkg::NODE_W-1:0] f_waddr, f_wdata, f_raddr, f_rdata;
	logic [wmpm_pkg::NODE_W-1:0] w_waddr, w_raddr;
	logic [31:0] w_wdata, w_rdata;
	logic [wmpm_pkg::NODE_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
	logic [wmpm_pkg::NODE_W-1:0] new_node;
	logic room;
	logic [32:0] wsum;
	logic [48:0] tsum;

	assign new_node = count_q[wmpm_pkg::NODE_W-1:0];
	assign room = tail_q < wmpm_pkg::MAX_COUNT;
	assign wsum = {1'b0, w_rdata} + {1'b0, wf_q};
	assign tsum = {1'b0, total_q} + 49'(w_rdata);

	wmpm_ram #(.AW(wmpm_pkg::GOTO_AW), .DW(wmpm_pkg::NODE_W),
			.DEPTH(wmpm_pkg::GOTO_DEPTH)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata));
	wmpm_ram #(.AW(wmpm_pkg::NODE_W), .DW(wmpm_pkg::NODE_W),
			.DEPTH(wmpm_pkg::MAX_NODES)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata));
	wmpm_ram #(.AW(wmpm_pkg::NODE_W), .DW(32),
			.DEPTH(wmpm_pkg::MAX_NODES)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata));
	wmpm_ram #(.AW(wmpm_pkg::NODE_W), .DW(wmpm_pkg::NODE_W),
			.DEPTH(wmpm_pkg::MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata));

	// Memory read addresses by state.
	always_comb begin
		g_raddr = wmpm_pkg::row_idx(cursor_q, req_q.symbol);
		f_raddr = q_rdata;
		w_raddr = g_rdata;
		q_raddr = head_q[wmpm_pkg::NODE_W-1:0];
		unique case (state_q)
			S_SC_RD: g_raddr = wmpm_pkg::row_idx(scan_q, req_q.symbol);
			S_B_R0:  g_raddr = wmpm_pkg::row_idx('0, k_q);
			S_B_C0:  g_raddr = wmpm_pkg::row_idx(f_q, k_q);
			S_B_C1:  g_raddr = wmpm_pkg::row_idx(now_q, k_q);
			S_B_F:   w_raddr = f_rdata;
			S_B_WF:  w_raddr = now_q;
			default: ;
		endcase
	end

	// Memory writes by state.
	always_comb begin
		g_we = 1'b0; g_waddr = wmpm_pkg::row_idx(now_q, k_q); g_wdata = '0;
		f_we = 1'b0; f_waddr = g_rdata; f_wdata = '0;
		w_we = 1'b0; w_waddr = g_rdata; w_wdata = 32'(req_q.weight);
		q_we = 1'b0; q_waddr = tail_q[wmpm_pkg::NODE_W-1:0]; q_wdata = g_rdata;
		unique case (state_q)
			S_CLR: begin
				g_we = 1'b1; g_waddr = wmpm_pkg::row_idx('0, k_q);
				w_we = (k_q == '0); w_waddr = '0; w_wdata = '0;
			end
			S_INS_CK: begin
				w_we = (g_rdata != '0) && req_q.pattern_end;
			end
			S_INS_Z: begin
				g_we = 1'b1; g_waddr = wmpm_pkg::row_idx(new_node, k_q);
				w_we = (k_q == '0); w_waddr = new_node;
				w_wdata = req_q.pattern_end ? 32'(req_q.weight) : '0;
			end
			S_INS_LK: begin
				g_we = 1'b1; g_waddr = wmpm_pkg::row_idx(cursor_q, req_q.symbol);
				g_wdata = new_node;
			end
			S_B_R0: begin
				f_we = (k_q == '0); f_waddr = '0;
			end
			S_B_R0D: begin
				f_we = (g_rdata != '0) && room;
				q_we = f_we;
			end
			S_B_WN: begin
				w_we = 1'b1; w_waddr = now_q;
				w_wdata = wsum[32] ? wmpm_pkg::W32MAX : wsum[31:0];
			end
			S_B_C2: begin
				g_we = (g_rdata == '0); g_wdata = via_q;
				f_we = (g_rdata != '0) && room; f_wdata = via_q;
				q_we = f_we;
			end
			default: ;
		endcase
	end

	// Sequencer and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			count_q <= wmpm_pkg::COUNT_W'(1);
			cursor_q <= '0;
			scan_q <= '0;
			total_q <= '0;
			built_q <= 1'b0;
			boot_q <= 1'b1;
			done_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			k_q <= '0;
		end else begin
			done_q <= 1'b0;
			rsp_q.status <= wmpm_pkg::ST_OK;
			rsp_q.match_weight <= '0;
			rsp_q.node <= scan_q;
			rsp_q.total_score <= total_q;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						k_q <= '0;
						priority if (req.kind == wmpm_pkg::K_CLEAR) begin
							state_q <= S_CLR;
						end else if (req.kind == wmpm_pkg::K_INSERT) begin
							if (built_q || req.symbol > wmpm_pkg::LAST_SYM) begin
								done_q <= 1'b1;
								rsp_q.node <= cursor_q;
							end else begin
								state_q <= S_INS_RD;
							end
						end else if (req.kind == wmpm_pkg::K_BUILD) begin
							if (built_q) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_B_R0;
								head_q <= '0;
								tail_q <= '0;
							end
						end else if (req.kind == wmpm_pkg::K_SCAN) begin
							if (!built_q) begin
								done_q <= 1'b1;
								rsp_q.status <= wmpm_pkg::ST_NOLINK;
							end else if (req.symbol > wmpm_pkg::LAST_SYM) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_SC_RD;
							end
						end else if (req.kind == wmpm_pkg::K_RESTART) begin
							done_q <= 1'b1;
							scan_q <= '0;
							total_q <= '0;
							rsp_q.node <= '0;
							rsp_q.total_score <= '0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				// Root row sweep on clear, and once after reset with no result.
				S_CLR: begin
					k_q <= k_q + 1'b1;
					if (k_q == wmpm_pkg::LAST_SYM) begin
						state_q <= S_IDLE;
						count_q <= wmpm_pkg::COUNT_W'(1);
						cursor_q <= '0;
						scan_q <= '0;
						total_q <= '0;
						built_q <= 1'b0;
						boot_q <= 1'b0;
						done_q <= !boot_q;
						rsp_q.node <= '0;
						rsp_q.total_score <= '0;
					end
				end
				S_INS_RD: state_q <= S_INS_CK;
				// Existing child, full table, or grow a node.
				S_INS_CK: begin
					if (g_rdata != '0) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						rsp_q.node <= g_rdata;
						cursor_q <= req_q.pattern_end ? '0 : g_rdata;
					end else if (count_q >= wmpm_pkg::MAX_COUNT) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						rsp_q.status <= wmpm_pkg::ST_FULL;
						rsp_q.node <= cursor_q;
						if (req_q.pattern_end) begin
							cursor_q <= '0;
						end
					end else begin
						state_q <= S_INS_Z;
					end
				end
				S_INS_Z: begin
					k_q <= k_q + 1'b1;
					if (k_q == wmpm_pkg::LAST_SYM) begin
						state_q <= S_INS_LK;
					end
				end
				S_INS_LK: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					rsp_q.node <= new_node;
					cursor_q <= req_q.pattern_end ? '0 : new_node;
					count_q <= count_q + 1'b1;
				end
				S_SC_RD: state_q <= S_SC_G;
				S_SC_G: begin
					state_q <= S_SC_W;
					scan_q <= g_rdata;
				end
				S_SC_W: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					total_q <= tsum[48] ? wmpm_pkg::W48MAX : tsum[47:0];
					rsp_q.node <= scan_q;
					rsp_q.match_weight <= w_rdata;
					rsp_q.total_score <= tsum[48] ? wmpm_pkg::W48MAX : tsum[47:0];
				end
				// Root children seed the queue.
				S_B_R0: state_q <= S_B_R0D;
				S_B_R0D: begin
					if (g_rdata != '0 && room) begin
						tail_q <= tail_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					state_q <= (k_q == wmpm_pkg::LAST_SYM) ? S_B_POP : S_B_R0;
				end
				S_B_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_IDLE;
						built_q <= 1'b1;
						done_q <= 1'b1;
					end else begin
						state_q <= S_B_POPD;
					end
				end
				S_B_POPD: begin
					now_q <= q_rdata;
					head_q <= head_q + 1'b1;
					state_q <= S_B_F;
				end
				S_B_F: begin
					f_q <= f_rdata;
					state_q <= S_B_WF;
				end
				S_B_WF: begin
					wf_q <= w_rdata;
					state_q <= S_B_WN;
				end
				S_B_WN: begin
					k_q <= '0;
					state_q <= S_B_C0;
				end
				S_B_C0: state_q <= S_B_C1;
				S_B_C1: begin
					via_q <= g_rdata;
					state_q <= S_B_C2;
				end
				// Fill a missing edge, or queue the child with its fail link.
				S_B_C2: begin
					if (g_rdata != '0 && room) begin
						tail_q <= tail_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					state_q <= (k_q == wmpm_pkg::LAST_SYM) ? S_B_POP : S_B_C0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= wmpm_pkg::COUNT_W'(1) && count_q <= wmpm_pkg::MAX_COUNT)
		else $error("node count out of range");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q && tail_q <= wmpm_pkg::MAX_COUNT)
		else $error("queue head passed tail");
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind == wmpm_pkg::K_SCAN && built_q
		&& req.symbol <= wmpm_pkg::LAST_SYM |=> busy && !done)
		else $error("scan did not start a lookup");
	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == wmpm_pkg::ST_FULL |-> $stable(count_q))
		else $error("full table still grew");
endmodule
`default_nettype wire

FILE: sim/tb_weighted_multi_pattern_matcher_top.sv
`timescale 1ns / 100ps
`default_nettype none

// Predicts each result from its own copy of the automaton and checks results in order.
class match_scoreboard;
	logic [wmpm_pkg::NODE_W-1:0] trans[wmpm_pkg::GOTO_DEPTH];
	logic [wmpm_pkg::NODE_W-1:0] fail_of[wmpm_pkg::MAX_NODES];
	logic [31:0] node_sum[wmpm_pkg::MAX_NODES];
	logic [wmpm_pkg::NODE_W-1:0] bfs[wmpm_pkg::MAX_NODES];
	int unsigned node_cnt;
	logic [wmpm_pkg::NODE_W-1:0] cursor;
	logic [wmpm_pkg::NODE_W-1:0] scan_at;
	logic [47:0] total;
	bit built;
	wmpm_pkg::rsp_t pending_rsp[$];
	int errors;
	int checked;
	int full_hits;
	int match_hits;

	function new();
		errors = 0;
		checked = 0;
		full_hits = 0;
		match_hits = 0;
		wipe();
	endfunction

	function int unsigned grow();
		int unsigned n;
		n = node_cnt;
		for (int i = 0; i < wmpm_pkg::ALPHABET; i++)
			trans[n * wmpm_pkg::ALPHABET + i] = '0;
		node_sum[n] = '0;
		node_cnt = n + 1;
		return n;
	endfunction

	function void wipe();
		node_cnt = 0;
		void'(grow());
		cursor = '0;
		scan_at = '0;
		total = '0;
		built = 0;
	endfunction

	function logic [31:0] add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? wmpm_pkg::W32MAX : s[31:0];
	endfunction

	// Breadth-first pass over the trie: fail links, full transitions, weight sums.
	function void link_trie();
		int unsigned head;
		int unsigned tail;
		logic [wmpm_pkg::NODE_W-1:0] now;
		logic [wmpm_pkg::NODE_W-1:0] f;
		logic [wmpm_pkg::NODE_W-1:0] c;
		logic [wmpm_pkg::NODE_W-1:0] via;
		head = 0;
		tail = 0;
		fail_of[0] = '0;
		for (int i = 0; i < wmpm_pkg::ALPHABET; i++) begin
			c = trans[i];
			if (c != 0 && tail < wmpm_pkg::MAX_NODES) begin
				fail_of[c] = '0;
				bfs[tail] = c;
				tail++;
			end
		end
		while (head < tail) begin
			now = bfs[head];
			head++;
			f = fail_of[now];
			node_sum[now] = add32(node_sum[now], node_sum[f]);
			for (int i = 0; i < wmpm_pkg::ALPHABET; i++) begin
				via = trans[f * wmpm_pkg::ALPHABET + i];
				c = trans[now * wmpm_pkg::ALPHABET + i];
				if (c == 0) begin
					trans[now * wmpm_pkg::ALPHABET + i] = via;
				end else if (tail < wmpm_pkg::MAX_NODES) begin
					fail_of[c] = via;
					bfs[tail] = c;
					tail++;
				end
			end
		end
		built = 1;
	endfunction

	// Notes an accepted request and queues the result it must cause.
	function void note_request(wmpm_pkg::req_t r);
		wmpm_pkg::rsp_t e;
		logic [wmpm_pkg::NODE_W-1:0] c;
		logic [48:0] s;
		int unsigned idx;
		e.status = wmpm_pkg::ST_OK;
		e.node = scan_at;
		e.match_weight = '0;
		case (r.kind)
			wmpm_pkg::K_CLEAR: begin
				wipe();
				e.node = '0;
			end
			wmpm_pkg::K_INSERT: begin
				e.node = cursor;
				if (!built && r.symbol < wmpm_pkg::ALPHABET) begin
					idx = cursor * wmpm_pkg::ALPHABET + r.symbol;
					c = trans[idx];
					if (c == 0 && node_cnt >= wmpm_pkg::MAX_NODES) begin
						e.status = wmpm_pkg::ST_FULL;
						full_hits++;
						if (r.pattern_end)
							cursor = '0;
					end else begin
						if (c == 0) begin
							c = wmpm_pkg::NODE_W'(grow());
							trans[idx] = c;
						end
						e.node = c;
						if (r.pattern_end) begin
							node_sum[c] = {16'd0, r.weight};
							cursor = '0;
						end else begin
							cursor = c;
						end
					end
				end
			end
			wmpm_pkg::K_BUILD: begin
				if (!built)
					link_trie();
			end
			wmpm_pkg::K_SCAN: begin
				if (!built) begin
					e.status = wmpm_pkg::ST_NOLINK;
				end else if (r.symbol < wmpm_pkg::ALPHABET) begin
					scan_at = trans[scan_at * wmpm_pkg::ALPHABET + r.symbol];
					e.node = scan_at;
					e.match_weight = node_sum[scan_at];
					if (e.match_weight != 0)
						match_hits++;
					s = {1'b0, total} + {17'd0, e.match_weight};
					total = s[48] ? wmpm_pkg::W48MAX : s[47:0];
				end
			end
			wmpm_pkg::K_RESTART: begin
				scan_at = '0;
				total = '0;
				e.node = '0;
			end
			default: ;
		endcase
		e.total_score = total;
		pending_rsp.push_back(e);
	endfunction

	// Compares one result with the oldest expectation.
	function void check_result(wmpm_pkg::rsp_t a);
		wmpm_pkg::rsp_t e;
		if (pending_rsp.size() == 0) begin
			$error("result with nothing expected: %h", a);
			errors++;
			return;
		end
		e = pending_rsp.pop_front();
		checked++;
		if (a.status !== e.status) begin
			$error("status: expected %0d, actual %0d", e.status, a.status);
			errors++;
		end
		if (a.node !== e.node) begin
			$error("node: expected %0d, actual %0d", e.node, a.node);
			errors++;
		end
		if (a.match_weight !== e.match_weight) begin
			$error("match_weight: expected %0d, actual %0d", e.match_weight, a.match_weight);
			errors++;
		end
		if (a.total_score !== e.total_score) begin
			$error("total_score: expected %0d, actual %0d", e.total_score, a.total_score);
			errors++;
		end
	endfunction
endclass

module tb_weighted_multi_pattern_matcher_top;
	localparam int CYCLE_LIMIT = 4000000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	wmpm_pkg::req_t req;
	logic done;
	wmpm_pkg::rsp_t rsp;

	match_scoreboard board;
	int burst_left;
	int sent;
	longint cycles;

	weighted_multi_pattern_matcher_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the whole run.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("weighted_multi_pattern_matcher_top regression: fail");
				$finish;
			end
		end
	end

	// Results cannot be held off, so every strobe is checked at once.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(rsp);
	end

	// Sends one request; bursts of back-to-back requests are split by random gaps.
	task automatic issue(input wmpm_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_request(r);
		sent++;
	endtask

	task automatic issue_kind(input logic [2:0] k, input logic [4:0] s, input logic pe,
			input logic [15:0] w);
		wmpm_pkg::req_t r;
		r.kind = k;
		r.symbol = s;
		r.pattern_end = pe;
		r.weight = w;
		issue(r);
	endtask

	task automatic insert_pattern(input int len, input int sym_hi);
		for (int i = 0; i < len; i++)
			issue_kind(wmpm_pkg::K_INSERT, 5'($urandom_range(0, sym_hi)), i == len - 1,
				16'($urandom()));
	endtask

	// A random request of any kind and any field values.
	task automatic issue_noise();
		issue_kind(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), 1'($urandom()),
			16'($urandom()));
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		burst_left = 0;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: duplicates, out-of-range symbols, order errors, unused kinds.
		issue_kind(wmpm_pkg::K_CLEAR, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_SCAN, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_INSERT, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_INSERT, 5'd1, 1'b1, 16'hFFFF);
		issue_kind(wmpm_pkg::K_INSERT, 5'd1, 1'b1, 16'd0);
		issue_kind(wmpm_pkg::K_INSERT, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_INSERT, 5'd1, 1'b1, 16'd7);
		issue_kind(wmpm_pkg::K_INSERT, 5'd25, 1'b1, 16'd3);
		issue_kind(wmpm_pkg::K_INSERT, 5'd31, 1'b1, 16'hAAAA);
		issue_kind(wmpm_pkg::K_INSERT, 5'd26, 1'b0, 16'h5555);
		issue_kind(wmpm_pkg::K_BUILD, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_BUILD, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_INSERT, 5'd2, 1'b1, 16'd9);
		issue_kind(wmpm_pkg::K_SCAN, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_SCAN, 5'd1, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_SCAN, 5'd25, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_SCAN, 5'd30, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_SCAN, 5'd24, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_RESTART, 5'd0, 1'b0, 16'd0);
		issue_kind(3'd5, 5'd31, 1'b1, 16'hFFFF);
		issue_kind(3'd6, 5'd0, 1'b0, 16'd0);
		issue_kind(3'd7, 5'd0, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_SCAN, 5'd1, 1'b0, 16'd0);
		issue_kind(wmpm_pkg::K_CLEAR, 5'd0, 1'b0, 16'd0);

		// Random sessions: build a small dictionary, link it, then scan text.
		while (sent < 200) begin
			if ($urandom_range(0, 7) != 0)
				issue_kind(wmpm_pkg::K_CLEAR, 5'($urandom()), 1'($urandom()),
					16'($urandom()));
			repeat ($urandom_range(1, 6)) begin
				insert_pattern($urandom_range(1, 4), ($urandom_range(0, 3) == 0) ? 25 : 3);
				if ($urandom_range(0, 9) == 0)
					issue_noise();
			end
			if ($urandom_range(0, 9) != 0)
				issue_kind(wmpm_pkg::K_BUILD, 5'($urandom()), 1'($urandom()),
					16'($urandom()));
			repeat ($urandom_range(5, 30)) begin
				case ($urandom_range(0, 19))
					0: issue_kind(wmpm_pkg::K_RESTART, 5'($urandom()), 1'($urandom()),
						16'($urandom()));
					1: issue_noise();
					2: issue_kind(wmpm_pkg::K_SCAN, 5'($urandom_range(0, 25)), 1'b0, 16'd0);
					default: issue_kind(wmpm_pkg::K_SCAN, 5'($urandom_range(0, 3)),
						1'($urandom()), 16'($urandom()));
				endcase
			end
		end

		// Fill the node table to the top, then push past it.
		issue_kind(wmpm_pkg::K_CLEAR, 5'd0, 1'b0, 16'd0);
		while (board.node_cnt < wmpm_pkg::MAX_NODES)
			insert_pattern($urandom_range(1, 8), 25);
		repeat (12)
			insert_pattern($urandom_range(1, 4), 25);
		issue_kind(wmpm_pkg::K_BUILD, 5'd0, 1'b0, 16'd0);
		repeat (60)
			issue_kind(wmpm_pkg::K_SCAN, 5'($urandom_range(0, 25)), 1'b0, 16'd0);

		start <= 1'b0;
		while (board.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d requests, checked %0d results, %0d nonzero matches,",
			sent, board.checked, board.match_hits);
		$display("%0d table-full drops, including a full 1024-node trie build.",
			board.full_hits);
		if (board.errors == 0 && board.pending_rsp.size() == 0)
			$display("weighted_multi_pattern_matcher_top regression: pass");
		else
			$display("weighted_multi_pattern_matcher_top regression: fail");
		$finish;
	end
endmodule

`default_nettype wire
